/* src/psm_pkg.sv */
// psm_pkg: shared types and constants of the plane psnr meter
// beat payload structs, configuration register codes and reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

    // geometry and sum widths
    localparam int MAX_SIDE_DEF = 4096;
    localparam int SUM_W        = 41;
    localparam int SIDE_CFG_W   = 13;
    localparam int SCALE_W      = 14;
    localparam int PSNR_W       = 21;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 2'd2;

    localparam logic [SIDE_CFG_W-1:0] RST_PLANE_WIDTH  = 13'd1920;
    localparam logic [SIDE_CFG_W-1:0] RST_PLANE_HEIGHT = 13'd1080;
    localparam logic [SCALE_W-1:0]    RST_OUTPUT_SCALE = 14'd100;

    // input beat
    typedef struct packed {
        logic [7:0] org_pixel;
        logic [7:0] rec_pixel;
        logic [1:0] plane_id;
        logic       last_pixel;
    } t_pix;

    // result beat
    typedef struct packed {
        logic [PSNR_W-1:0] psnr_scaled;
        logic [1:0]        out_plane;
        logic              exact_match;
    } t_res;

    // finished plane handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] ssd;
        logic [1:0]       plane;
    } t_job;

    // configuration seen by the back end
    typedef struct packed {
        logic [SIDE_CFG_W-1:0] plane_width;
        logic [SIDE_CFG_W-1:0] plane_height;
        logic [SCALE_W-1:0]    output_scale;
    } t_cfg;

endpackage

`default_nettype wire

/* src/plane_psnr_meter.sv */
// plane_psnr_meter: top level of the plane psnr meter
// configuration registers and the front, queue and back instances
// depends on psm_pkg, psm_front, psm_job_queue, psm_back
//
// Pixel pairs of one plane enter in raster order at one beat per cycle while the
// job queue has room; each beat adds its squared error to a saturating 41-bit
// sum, and the beat marked last closes the plane and hands the sum to a two-entry
// job queue. A back end works through one job at a time on a single shared 32x32
// multiplier; a non-zero sum goes through one-bit normalising shifts of the two
// log2 operands, and an exact match takes a shorter path. Pixel beats stall only
// when two closed planes already wait in the job queue, so, with results popped,
// planes that stream for longer than the back end works on a job run at one pixel
// per cycle. Results wait in an output slot until popped. Configuration is to be
// written only while the block is idle; the block itself does not enforce this,
// and the write port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module plane_psnr_meter
    import psm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire t_pix                  i_pix,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output t_res                       o_res,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic job_push;
    t_job job_in;
    logic job_full;
    logic job_valid;
    t_job job_out;
    logic job_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_width  <= RST_PLANE_WIDTH;
            r_cfg.plane_height <= RST_PLANE_HEIGHT;
            r_cfg.output_scale <= RST_OUTPUT_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PLANE_WIDTH:  r_cfg.plane_width  <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_PLANE_HEIGHT: r_cfg.plane_height <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_OUTPUT_SCALE: r_cfg.output_scale <= i_cfg_data[SCALE_W-1:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    // pixel intake and error sum
    psm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_pix      (i_pix),
        .o_full     (o_full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    // closed planes waiting for the back end
    psm_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .o_valid (job_valid),
        .o_job   (job_out),
        .i_pop   (job_pop)
    );

    // log, scaling and result slot
    psm_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_cfg       (r_cfg),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

/* src/psm_front.sv */
// psm_front: per-pixel squared error accumulation
// closes a plane on the last beat and pushes its error sum as a job
// depends on psm_pkg
`timescale 1ns / 1ps
`default_nettype none

module psm_front
    import psm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_pix i_pix,
    output logic      o_full,
    output logic      o_job_push,
    output t_job      o_job,
    input  wire logic i_job_full
);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [7:0]       abs_diff;
    logic [15:0]      sq_err;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_sat;
    logic             accept;

    // stall only when the job queue has no room
    assign o_full = i_job_full;
    assign accept = i_push && !i_job_full;

    // squared error and saturating add
    always_comb begin
        abs_diff = (i_pix.rec_pixel >= i_pix.org_pixel) ?
                   (i_pix.rec_pixel - i_pix.org_pixel) :
                   (i_pix.org_pixel - i_pix.rec_pixel);
        sq_err   = abs_diff * abs_diff;
        sum_ext  = {1'b0, r_sum} + (SUM_W+1)'(sq_err);
        sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end

    // last beat closes the plane
    always_comb begin
        n_sum      = r_sum;
        o_job_push = 1'b0;
        o_job.ssd   = sum_sat;
        o_job.plane = i_pix.plane_id;
        if (accept) begin
            if (i_pix.last_pixel) begin
                o_job_push = 1'b1;
                n_sum      = '0;
            end else begin
                n_sum = sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // a closed plane always leaves a cleared sum behind
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_pix.last_pixel) |=> (r_sum == '0))
        else $error("error sum not cleared after last beat");

endmodule

`default_nettype wire

/* src/psm_job_queue.sv */
// psm_job_queue: two-entry queue of finished plane sums
// decouples pixel intake from the log and scaling back end
// depends on psm_pkg
`timescale 1ns / 1ps
`default_nettype none

module psm_job_queue
    import psm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push && !o_full, i_pop && o_valid})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/psm_back.sv */
// psm_back: per-plane psnr from the error sum
// sequencer around one shared 32x32 multiplier: log2 by squaring, scaling, rounding
// depends on psm_pkg
`timescale 1ns / 1ps
`default_nettype none

module psm_back
    import psm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire t_cfg i_cfg,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_res
);

    // widths derived from the largest side
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int NUM_W    = 2 * SIDE_W + 16;
    localparam int LW       = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int E_W      = $clog2(LW);
    localparam int FRAC_W   = 24;
    localparam int L_W      = E_W + FRAC_W;
    localparam int K_W      = 30;
    localparam int DK_W     = L_W + K_W;
    localparam int P_HI_W   = DK_W - 52;
    localparam int EX_W     = 28;
    localparam int Q_W      = 22;
    localparam int CNT_W    = $clog2(FRAC_W);

    localparam logic [31:0] PEAK_SQ     = 32'd65025;
    localparam logic [31:0] TEN_LOG2_K  = 32'd808071242;
    localparam logic [31:0] EXACT_X100  = 32'd9999;
    localparam logic [31:0] RECIP_100   = 32'd171798691;
    localparam logic [31:0] HUNDRED     = 32'd100;
    localparam logic [EX_W-1:0] HALF_HUNDRED = EX_W'(50);
    localparam logic [13:0] SIDE_LIMIT  = 14'(MAX_SIDE);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NUM  = 4'd1;
    localparam logic [3:0] S_NUM2 = 4'd2;
    localparam logic [3:0] S_LDN  = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_SQ0  = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;
    localparam logic [3:0] S_LOGD = 4'd7;
    localparam logic [3:0] S_PK   = 4'd8;
    localparam logic [3:0] S_PLO  = 4'd9;
    localparam logic [3:0] S_PHI  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_EX1  = 4'd12;
    localparam logic [3:0] S_EX2  = 4'd13;
    localparam logic [3:0] S_EX3  = 4'd14;
    localparam logic [3:0] S_EX4  = 4'd15;

    logic [3:0]        r_state;
    logic [SUM_W-1:0]  r_ssd;
    logic [1:0]        r_plane;
    logic [63:0]       r_prod;
    logic [63:0]       r_acc;
    logic [LW-1:0]     r_x;
    logic [E_W-1:0]    r_e;
    logic [FRAC_W-1:0] r_frac;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_which;
    logic [L_W-1:0]    r_ln;
    logic [L_W-1:0]    r_diff;
    logic [P_HI_W-1:0] r_phi;
    logic [Q_W-1:0]    r_q;
    logic              r_out_valid;
    t_res              r_out;

    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic [13:0]       w_ext;
    logic [13:0]       h_ext;
    logic [32:0]       sq_top;
    logic              sq_bit;
    logic [31:0]       sq_m;
    logic [L_W-1:0]    log_val;
    logic [EX_W-1:0]   ex_x;
    logic [EX_W-1:0]   ex_rem;
    logic [Q_W-1:0]    ex_q;
    logic [71:0]       fin_sum;
    logic [39:0]       fin_res;

    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid && !r_out_valid;

    // side clamping: zero reads as one, oversize as the largest side
    always_comb begin
        w_ext  = {1'b0, i_cfg.plane_width};
        h_ext  = {1'b0, i_cfg.plane_height};
        side_w = (w_ext == '0) ? SIDE_W'(1) :
                 (w_ext > SIDE_LIMIT) ? SIDE_W'(MAX_SIDE) : SIDE_W'(w_ext);
        side_h = (h_ext == '0) ? SIDE_W'(1) :
                 (h_ext > SIDE_LIMIT) ? SIDE_W'(MAX_SIDE) : SIDE_W'(h_ext);
    end

    // squaring step of the log: one fraction bit per product
    always_comb begin
        sq_top  = r_prod[63:31];
        sq_bit  = sq_top[32];
        sq_m    = sq_bit ? sq_top[32:1] : sq_top[31:0];
        log_val = {r_e, r_frac};
    end

    // exact-match rounding and final rounding helpers
    always_comb begin
        ex_x    = r_prod[EX_W-1:0] + HALF_HUNDRED;
        ex_rem  = r_acc[EX_W-1:0] - r_prod[EX_W-1:0];
        ex_q    = (ex_rem >= EX_W'(100)) ? (r_q + Q_W'(1)) : r_q;
        fin_sum = {8'd0, r_acc} + ({8'd0, r_prod} << 32) + (72'd1 << 31);
        fin_res = fin_sum[71:32];
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_NUM: begin
                mul_a = 32'(side_w);
                mul_b = 32'(side_h);
            end
            S_NUM2: begin
                mul_a = 32'(r_prod[2*SIDE_W-1:0]);
                mul_b = PEAK_SQ;
            end
            S_SQ0: begin
                mul_a = r_x[LW-1 -: 32];
                mul_b = r_x[LW-1 -: 32];
            end
            S_SQ: begin
                mul_a = sq_m;
                mul_b = sq_m;
            end
            S_PK: begin
                mul_a = 32'(r_diff);
                mul_b = TEN_LOG2_K;
            end
            S_PLO: begin
                mul_a = 32'(i_cfg.output_scale);
                mul_b = r_prod[51:20];
            end
            S_PHI: begin
                mul_a = 32'(i_cfg.output_scale);
                mul_b = 32'(r_phi);
            end
            S_EX1: begin
                mul_a = 32'(i_cfg.output_scale);
                mul_b = EXACT_X100;
            end
            S_EX2: begin
                mul_a = 32'(ex_x);
                mul_b = RECIP_100;
            end
            S_EX3: begin
                mul_a = 32'(r_prod[Q_W+33:34]);
                mul_b = HUNDRED;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_job_pop) begin
                    r_ssd   <= i_job.ssd;
                    r_plane <= i_job.plane;
                end
            end
            S_NUM, S_NUM2, S_PK, S_EX1: begin
                r_prod <= mul_p;
            end
            S_LDN: begin
                r_x     <= r_prod[LW-1:0];
                r_e     <= E_W'(LW - 1);
                r_which <= 1'b0;
            end
            S_NORM: begin
                if (!r_x[LW-1]) begin
                    r_x <= r_x << 1;
                    r_e <= r_e - E_W'(1);
                end
            end
            S_SQ0: begin
                r_prod <= mul_p;
                r_cnt  <= '0;
            end
            S_SQ: begin
                r_prod <= mul_p;
                r_frac <= {r_frac[FRAC_W-2:0], sq_bit};
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            S_LOGD: begin
                if (!r_which) begin
                    r_ln    <= log_val;
                    r_x     <= LW'(r_ssd);
                    r_e     <= E_W'(LW - 1);
                    r_which <= 1'b1;
                end else begin
                    r_diff <= r_ln - log_val;
                end
            end
            S_PLO: begin
                r_phi  <= r_prod[DK_W-1:52];
                r_prod <= mul_p;
            end
            S_PHI: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            S_EX2: begin
                r_acc  <= 64'(ex_x);
                r_prod <= mul_p;
            end
            S_EX3: begin
                r_q    <= r_prod[Q_W+33:34];
                r_prod <= mul_p;
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    // sequencer and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= (i_job.ssd == '0) ? S_EX1 : S_NUM;
                    end
                end
                S_NUM:  r_state <= S_NUM2;
                S_NUM2: r_state <= S_LDN;
                S_LDN:  r_state <= S_NORM;
                S_NORM: begin
                    if (r_x[LW-1]) begin
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0:  r_state <= S_SQ;
                S_SQ: begin
                    if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                        r_state <= S_LOGD;
                    end
                end
                S_LOGD: begin
                    if (!r_which) begin
                        r_state <= S_NORM;
                    end else if (r_ln > log_val) begin
                        r_state <= S_PK;
                    end else begin
                        r_out.psnr_scaled <= '0;
                        r_out.out_plane   <= r_plane;
                        r_out.exact_match <= 1'b0;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_PK:   r_state <= S_PLO;
                S_PLO:  r_state <= S_PHI;
                S_PHI:  r_state <= S_FIN;
                S_FIN: begin
                    r_out.psnr_scaled <= (fin_res > 40'((1 << PSNR_W) - 1)) ?
                                         {PSNR_W{1'b1}} : fin_res[PSNR_W-1:0];
                    r_out.out_plane   <= r_plane;
                    r_out.exact_match <= 1'b0;
                    r_out_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_EX1:  r_state <= S_EX2;
                S_EX2:  r_state <= S_EX3;
                S_EX3:  r_state <= S_EX4;
                S_EX4: begin
                    r_out.psnr_scaled <= (ex_q > Q_W'((1 << PSNR_W) - 1)) ?
                                         {PSNR_W{1'b1}} : ex_q[PSNR_W-1:0];
                    r_out.out_plane   <= r_plane;
                    r_out.exact_match <= 1'b1;
                    r_out_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
            endcase
        end
    end

    // result slot stays free while a plane is being worked on
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result slot busy during computation");

    // normalisation always has a set bit to find
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_x != '0))
        else $error("log of zero requested");

    // taking a job always starts work
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state != S_IDLE))
        else $error("job taken without starting");

endmodule

`default_nettype wire
